// ===== rtl/csrp_pkg.sv =====
`default_nettype none
package csrp_pkg;

  localparam int ACTION_W     = 2;
  localparam int VALUE_W      = 32;
  localparam int DRAW_W       = 16;
  localparam int STATUS_W     = 3;
  localparam int COUNT_OUT_W  = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PICK   = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/compact_set_with_random_pick.sv =====
`default_nettype none
// compact_set_with_random_pick
//
// A set of distinct 32-bit signed values kept packed at store indices
// 0 .. count-1. One command beat: start high while busy is low accepts
// action, value and random_draw. Exactly one result beat follows, shown
// for one cycle with done high: status, picked_value, element_count.
// The receiver cannot stall; results must be taken the cycle they appear.
//
// Insert / remove search the live entries with one comparator through the
// store's single registered read port, one entry per cycle: insert on a
// miss then appends, remove on a hit then reads the last entry and moves
// it into the hole. Pick runs draw modulo count in a bit-serial divider,
// 16 steps, then one store read. Pick on an empty set and the unused
// action code are answered in the cycle after they are taken. busy stays
// high while an item is in work (the answers at once leave it low); the
// next command is taken on the cycle its result is shown.
//
// Reset (rst, synchronous) empties the set; store contents are not
// cleared, only entries below the count are ever read.
module compact_set_with_random_pick #(
  parameter int CAPACITY = csrp_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [csrp_pkg::ACTION_W-1:0]  action,
  input  wire logic signed [csrp_pkg::VALUE_W-1:0] value,
  input  wire logic [csrp_pkg::DRAW_W-1:0]    random_draw,
  output logic                               busy,
  output logic                               done,
  output logic [csrp_pkg::STATUS_W-1:0]       status,
  output logic signed [csrp_pkg::VALUE_W-1:0] picked_value,
  output logic [csrp_pkg::COUNT_OUT_W-1:0]    element_count
);
  import csrp_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_INS,
    S_REM_RD,
    S_REM_WR,
    S_MOD,
    S_PICK_GET
  } state_t;

  state_t             state;
  action_t            act_q;
  logic [VALUE_W-1:0] value_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;       // next entry to read
  logic               pend;      // a read is in flight
  logic [AW-1:0]      pend_idx;  // entry that read belongs to
  logic [AW-1:0]      hit_idx;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  logic               accept;
  logic               mod_start;
  logic               mod_done;
  logic [CW-1:0]      mod_rem;
  logic               hit;
  logic               last_cmp;

  assign busy          = (state != S_IDLE);
  assign accept        = start && !busy;
  assign mod_start     = accept && (action == ACT_PICK) && (count != '0);
  assign element_count = COUNT_OUT_W'(count);

  // comparator on the entry read last cycle
  assign hit      = pend && (mem_rdata == value_q);
  assign last_cmp = !pend && (idx == count);

  // store port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = value_q;
    mem_re    = 1'b0;
    mem_raddr = idx[AW-1:0];
    unique case (state)
      S_SEARCH: begin
        mem_re = (idx < count);
      end
      S_INS: begin
        mem_we = (count < CW'(CAPACITY));
      end
      S_REM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(count - 1'b1);
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx;
        mem_wdata = mem_rdata;
      end
      S_MOD: begin
        mem_re    = mod_done;
        mem_raddr = mod_rem[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      pend  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act_q   <= action_t'(action);
            value_q <= value;
            idx     <= '0;
            pend    <= 1'b0;
            case (action) inside
              ACT_INSERT, ACT_REMOVE: state <= S_SEARCH;
              ACT_PICK: begin
                if (count == '0) begin
                  done         <= 1'b1;
                  status       <= ST_EMPTY;
                  picked_value <= '0;
                end else begin
                  state <= S_MOD;
                end
              end
              default: begin
                // unused code: no change
                done         <= 1'b1;
                status       <= ST_OK;
                picked_value <= '0;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            pend <= 1'b0;
            if (act_q == ACT_INSERT) begin
              done         <= 1'b1;
              status       <= ST_PRESENT;
              picked_value <= '0;
              state        <= S_IDLE;
            end else begin
              hit_idx <= pend_idx;
              state   <= S_REM_RD;
            end
          end else if (last_cmp) begin
            if (act_q == ACT_INSERT) begin
              state <= S_INS;
            end else begin
              done         <= 1'b1;
              status       <= ST_ABSENT;
              picked_value <= '0;
              state        <= S_IDLE;
            end
          end else begin
            pend     <= mem_re;
            pend_idx <= idx[AW-1:0];
            if (mem_re) begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_INS: begin
          done         <= 1'b1;
          picked_value <= '0;
          if (count < CW'(CAPACITY)) begin
            status <= ST_OK;
            count  <= count + 1'b1;
          end else begin
            status <= ST_FULL;
          end
          state <= S_IDLE;
        end
        S_REM_RD: begin
          state <= S_REM_WR;
        end
        S_REM_WR: begin
          count        <= count - 1'b1;
          done         <= 1'b1;
          status       <= ST_OK;
          picked_value <= '0;
          state        <= S_IDLE;
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_PICK_GET;
          end
        end
        S_PICK_GET: begin
          done         <= 1'b1;
          status       <= ST_OK;
          picked_value <= mem_rdata;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  csrp_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  csrp_mod #(
    .CW (CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (random_draw),
    .divisor  (count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // live count never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("live count above capacity");

  // an accepted command keeps the block busy unless it answers at once
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("command accepted without work or result");

  // empty status only with an empty set and no picked value
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (count == '0 && picked_value == '0))
    else $error("empty status with live elements");

  // pick read is issued only with an in-range remainder
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (mod_rem < count))
    else $error("pick index out of range");

endmodule
`default_nettype wire

// ===== rtl/csrp_store.sv =====
`default_nettype none
module csrp_store #(
  parameter int DEPTH = csrp_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [csrp_pkg::VALUE_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [csrp_pkg::VALUE_W-1:0] rdata
);
  import csrp_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csrp_mod.sv =====
`default_nettype none
module csrp_mod #(
  parameter int CW = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [csrp_pkg::DRAW_W-1:0] dividend,
  input  wire logic [CW-1:0]              divisor,
  output logic                            done,
  output logic [CW-1:0]                   rem
);
  import csrp_pkg::*;

  localparam int BW = $clog2(DRAW_W + 1);

  typedef enum logic {M_IDLE, M_RUN} mstate_t;

  mstate_t           state;
  logic [DRAW_W-1:0] dvd;
  logic [CW-1:0]     dvs;
  logic [BW-1:0]     bits_left;
  logic [CW:0]       trial;
  logic [CW:0]       diff;
  logic [CW-1:0]     rem_next;

  // restoring step: shift in one dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, dvd[DRAW_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[CW-1:0];
    end else begin
      rem_next = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= M_IDLE;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            dvd       <= dividend;
            dvs       <= divisor;
            rem       <= '0;
            bits_left <= BW'(DRAW_W);
            state     <= M_RUN;
          end
        end
        M_RUN: begin
          rem       <= rem_next;
          dvd       <= {dvd[DRAW_W-2:0], 1'b0};
          bits_left <= bits_left - 1'b1;
          if (bits_left == BW'(1)) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/csrp_checker.sv =====
`default_nettype none
module csrp_checker #(
  parameter int CAPACITY = csrp_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic                                 busy,
  input  wire logic [csrp_pkg::ACTION_W-1:0]         action,
  input  wire logic signed [csrp_pkg::VALUE_W-1:0]   value,
  input  wire logic [csrp_pkg::DRAW_W-1:0]           random_draw,
  input  wire logic                                 done,
  input  wire logic [csrp_pkg::STATUS_W-1:0]         status,
  input  wire logic signed [csrp_pkg::VALUE_W-1:0]   picked_value,
  input  wire logic [csrp_pkg::COUNT_OUT_W-1:0]      element_count,
  output int                                        fail_count,
  output int                                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import csrp_pkg::*;

  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] picked;
    logic [COUNT_OUT_W-1:0]    count;
  } set_result_t;

  // shadow copy of the packed store and its fill level
  logic signed [VALUE_W-1:0] members [CAPACITY];
  int                        live_count;
  set_result_t               expected_results [$];
  int                        errors;

  initial begin
    fail_count = 0;
    pending    = 0;
    errors     = 0;
    live_count = 0;
  end

  // Applies one command to the shadow set and returns the result beat it must produce.
  function automatic set_result_t apply_set_op(logic [ACTION_W-1:0] act,
                                               logic signed [VALUE_W-1:0] v,
                                               logic [DRAW_W-1:0] draw);
    set_result_t r;
    int          pos;
    r.status = ST_OK;
    r.picked = '0;
    pos      = -1;
    for (int i = 0; i < live_count; i++)
      if (pos < 0 && members[i] == v) pos = i;
    case (act)
      ACT_INSERT: begin
        if (pos >= 0) r.status = ST_PRESENT;
        else if (live_count >= CAPACITY) r.status = ST_FULL;
        else begin
          members[live_count] = v;
          live_count++;
        end
      end
      ACT_REMOVE: begin
        if (pos < 0) r.status = ST_ABSENT;
        else begin
          // hole is filled by the last live entry
          members[pos] = members[live_count-1];
          live_count--;
        end
      end
      ACT_PICK: begin
        if (live_count == 0) r.status = ST_EMPTY;
        else r.picked = members[int'(draw) % live_count];
      end
      default: ;  // unused code: no effect
    endcase
    r.count = COUNT_OUT_W'(live_count);
    return r;
  endfunction

  always @(posedge clk) begin
    set_result_t exp_beat;
    set_result_t pred_beat;
    if (rst) begin
      live_count = 0;
      expected_results.delete();
    end else begin
      // a result beat belongs to an earlier command, so check it before a new accept
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding: status=%0d picked_value=%0d count=%0d",
                 status, picked_value, element_count);
          errors++;
        end else begin
          exp_beat = expected_results.pop_front();
          if (status !== exp_beat.status) begin
            $error("status: expected %0d, got %0d", exp_beat.status, status);
            errors++;
          end
          if (picked_value !== exp_beat.picked) begin
            $error("picked_value: expected %0d, got %0d", exp_beat.picked, picked_value);
            errors++;
          end
          if (element_count !== exp_beat.count) begin
            $error("element_count: expected %0d, got %0d", exp_beat.count, element_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        pred_beat        = apply_set_op(action, value, random_draw);
        expected_results = {expected_results, pred_beat};
      end
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule
`default_nettype wire

// ===== tb/compact_set_with_random_pick_test.sv =====
`default_nettype none
module compact_set_with_random_pick_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csrp_pkg::*;

  // action code that the block does not define; it must be answered and ignored
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_TAIL    = 150;     // final beats sent back to back
  localparam int POOL_SIZE    = 96;      // more than capacity, so the store can fill
  localparam int TAIL_CYCLES  = 100;     // longer than the slowest item
  localparam int CYCLE_LIMIT  = 1_000_000;

  // random traffic runs in segments, each leaning toward one kind of command
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX} segment_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [ACTION_W-1:0]         action = '0;
  logic signed [VALUE_W-1:0]   value = '0;
  logic [DRAW_W-1:0]           random_draw = '0;
  logic                        busy;
  logic                        done;
  logic [STATUS_W-1:0]         status;
  logic signed [VALUE_W-1:0]   picked_value;
  logic [COUNT_OUT_W-1:0]      element_count;
  int                          fail_count;
  int                          pending;
  int                          cycles = 0;

  // values to draw from, and the values that may be in the set right now
  // (a superset: inserts refused by a full store stay listed)
  logic signed [VALUE_W-1:0]   value_pool [POOL_SIZE];
  logic signed [VALUE_W-1:0]   maybe_members [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  compact_set_with_random_pick u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .value         (value),
    .random_draw   (random_draw),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .picked_value  (picked_value),
    .element_count (element_count)
  );

  csrp_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .value         (value),
    .random_draw   (random_draw),
    .done          (done),
    .status        (status),
    .picked_value  (picked_value),
    .element_count (element_count),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one command beat and returns at the edge that takes it.
  // start is left high, so a following beat goes out with no gap.
  task automatic issue_command(input logic [ACTION_W-1:0] act,
                               input logic signed [VALUE_W-1:0] v,
                               input logic [DRAW_W-1:0] d);
    start       <= 1'b1;
    action      <= act;
    value       <= v;
    random_draw <= d;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  // One random command. Inserts draw mostly from the pool so that duplicates
  // and a full store happen; removes mostly target values that may be live
  // so that drain segments can really empty the set.
  task automatic random_command(input segment_t seg);
    int                        roll;
    int                        idx;
    int                        ins_pct;
    int                        rem_pct;
    bit                        listed;
    logic [ACTION_W-1:0]       act;
    logic signed [VALUE_W-1:0] v;
    logic [DRAW_W-1:0]         d;
    case (seg)
      SEG_FILL:  begin ins_pct = 70; rem_pct = 12; end
      SEG_DRAIN: begin ins_pct = 12; rem_pct = 70; end
      default:   begin ins_pct = 35; rem_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) act = ACT_INSERT;
    else if (roll < ins_pct + rem_pct) act = ACT_REMOVE;
    else if (roll < 97) act = ACT_PICK;
    else act = ACT_UNUSED;

    // draw extremes show up often: zero and all ones
    roll = $urandom_range(0, 9);
    if (roll == 0) d = '0;
    else if (roll == 1) d = '1;
    else d = DRAW_W'($urandom_range(0, 65535));

    v = $urandom;
    if (act == ACT_INSERT) begin
      if ($urandom_range(0, 9) != 0) v = value_pool[$urandom_range(0, POOL_SIZE-1)];
      listed = 1'b0;
      foreach (maybe_members[i]) if (maybe_members[i] == v) listed = 1'b1;
      if (!listed) maybe_members = {maybe_members, v};
    end else if (act == ACT_REMOVE) begin
      if (maybe_members.size() != 0 && $urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, maybe_members.size() - 1);
        v   = maybe_members[idx];
        maybe_members.delete(idx);
      end else if ($urandom_range(0, 1) == 0) begin
        v = value_pool[$urandom_range(0, POOL_SIZE-1)];
      end
    end
    issue_command(act, v, d);
  endtask

  initial begin
    int       sent;
    int       seg_len;
    bit       calm;
    segment_t seg;

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-set corners, the unused code, value extremes,
    // a duplicate insert, picks at draw extremes, removal from the middle,
    // the end and the front, and draining back to empty.
    issue_command(ACT_PICK,   '0, '0);                 // pick on empty set
    issue_command(ACT_REMOVE, 32'sd5, '0);             // remove from empty set
    issue_command(ACT_UNUSED, '0, '0);
    issue_command(ACT_INSERT, 32'sh8000_0000, '1);
    issue_command(ACT_INSERT, 32'sh7FFF_FFFF, '0);
    idle_burst();
    issue_command(ACT_INSERT, '0, '0);
    issue_command(ACT_INSERT, '1, '0);
    issue_command(ACT_INSERT, 32'sh8000_0000, '0);     // already present
    issue_command(ACT_PICK,   '0, '0);
    issue_command(ACT_PICK,   '1, '1);                 // draw all ones
    issue_command(ACT_PICK,   '0, 16'd2);
    issue_command(ACT_REMOVE, '0, '0);                 // middle: last entry moves in
    issue_command(ACT_REMOVE, '0, '0);                 // now absent
    issue_command(ACT_REMOVE, '1, '0);
    issue_command(ACT_UNUSED, 32'sh5A5A_A5A5, '1);     // ignored even with fields set
    issue_command(ACT_PICK,   '0, '1);
    idle_burst();
    issue_command(ACT_REMOVE, 32'sh8000_0000, '0);     // front entry
    issue_command(ACT_REMOVE, 32'sh7FFF_FFFF, '0);     // set is empty again
    issue_command(ACT_PICK,   '0, '1);

    // Random: segments that fill, drain or mix; some segments never idle,
    // and the final stretch runs back to back.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg     = segment_t'($urandom_range(0, 2));
      seg_len = $urandom_range(40, 200);
      calm    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        random_command(seg);
        sent++;
        if (!calm && sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
          idle_burst();
      end
    end
    start <= 1'b0;

    // drain outstanding results, then watch a while for stray beats
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// ===== compact_set_with_random_pick.f =====
rtl/csrp_pkg.sv
rtl/csrp_store.sv
rtl/csrp_mod.sv
rtl/compact_set_with_random_pick.sv
tb/csrp_checker.sv
tb/compact_set_with_random_pick_test.sv
